>>> hdl/fmpm_pkg.sv
// Shared types and constants for the motor fault protection monitor.
`default_nettype none

package fmpm_pkg;

    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int COUNTER_WIDTH_DEF = 16;

    localparam int REG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int VBUS_W     = 16;
    localparam int PEAK_W     = 16;
    localparam int FLAGS_W    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OC_LIMIT       = 3'd0,
        REG_OV_LIMIT       = 3'd1,
        REG_UV_LIMIT       = 3'd2,
        REG_STALL_ERR_LIM  = 3'd3,
        REG_STALL_CNT_LIM  = 3'd4,
        REG_STALL_MIN_CMD  = 3'd5,
        REG_STALL_MAX_FDB  = 3'd6
    } t_reg_idx;

    localparam logic ACT_CHECK = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    localparam int FLT_OC    = 0;
    localparam int FLT_OV    = 1;
    localparam int FLT_UV    = 2;
    localparam int FLT_STALL = 3;

    localparam logic [REG_W-1:0] RST_OC_LIMIT      = 16'd32768;
    localparam logic [REG_W-1:0] RST_OV_LIMIT      = 16'd65535;
    localparam logic [REG_W-1:0] RST_UV_LIMIT      = 16'd0;
    localparam logic [REG_W-1:0] RST_STALL_ERR_LIM = 16'd65535;
    localparam logic [REG_W-1:0] RST_STALL_CNT_LIM = 16'd65535;
    localparam logic [REG_W-1:0] RST_STALL_MIN_CMD = 16'd0;
    localparam logic [REG_W-1:0] RST_STALL_MAX_FDB = 16'd0;

    typedef struct packed {
        logic [REG_W-1:0] oc_limit;
        logic [REG_W-1:0] ov_limit;
        logic [REG_W-1:0] uv_limit;
        logic [REG_W-1:0] stall_err_lim;
        logic [REG_W-1:0] stall_cnt_lim;
        logic [REG_W-1:0] stall_min_cmd;
        logic [REG_W-1:0] stall_max_fdb;
    } t_limits;

endpackage

`default_nettype wire

>>> hdl/fmpm_cfg_regs.sv
// Configuration register file holding the protection limits.
`default_nettype none

module fmpm_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [fmpm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [fmpm_pkg::REG_W-1:0]    i_cfg_data,
    output fmpm_pkg::t_limits                  o_limits
);
    import fmpm_pkg::*;

    t_limits r_limits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.oc_limit      <= RST_OC_LIMIT;
            r_limits.ov_limit      <= RST_OV_LIMIT;
            r_limits.uv_limit      <= RST_UV_LIMIT;
            r_limits.stall_err_lim <= RST_STALL_ERR_LIM;
            r_limits.stall_cnt_lim <= RST_STALL_CNT_LIM;
            r_limits.stall_min_cmd <= RST_STALL_MIN_CMD;
            r_limits.stall_max_fdb <= RST_STALL_MAX_FDB;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_OC_LIMIT:      r_limits.oc_limit      <= i_cfg_data;
                REG_OV_LIMIT:      r_limits.ov_limit      <= i_cfg_data;
                REG_UV_LIMIT:      r_limits.uv_limit      <= i_cfg_data;
                REG_STALL_ERR_LIM: r_limits.stall_err_lim <= i_cfg_data;
                REG_STALL_CNT_LIM: r_limits.stall_cnt_lim <= i_cfg_data;
                REG_STALL_MIN_CMD: r_limits.stall_min_cmd <= i_cfg_data;
                REG_STALL_MAX_FDB: r_limits.stall_max_fdb <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_limits = r_limits;

endmodule

`default_nettype wire

>>> hdl/fmpm_eval.sv
// Per-item fault evaluation: peak current, bus voltage and stall checks, or a clear.
`default_nettype none

module fmpm_eval #(
    parameter int SAMPLE_WIDTH  = fmpm_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNTER_WIDTH = fmpm_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic                               i_action,
    input  wire logic signed [SAMPLE_WIDTH-1:0]     i_phase_a_current,
    input  wire logic signed [SAMPLE_WIDTH-1:0]     i_phase_b_current,
    input  wire logic signed [SAMPLE_WIDTH-1:0]     i_phase_c_current,
    input  wire logic [fmpm_pkg::VBUS_W-1:0]        i_bus_voltage,
    input  wire logic signed [SAMPLE_WIDTH-1:0]     i_speed_command,
    input  wire logic signed [SAMPLE_WIDTH-1:0]     i_speed_feedback,
    input  wire logic                               i_motor_running,
    input  wire fmpm_pkg::t_limits                  i_limits,
    input  wire logic [fmpm_pkg::FLAGS_W-1:0]       i_latched,
    input  wire logic [COUNTER_WIDTH-1:0]           i_stall_cnt,
    output logic [fmpm_pkg::FLAGS_W-1:0]            o_latched,
    output logic [COUNTER_WIDTH-1:0]                o_stall_cnt,
    output logic [fmpm_pkg::PEAK_W-1:0]             o_peak
);
    import fmpm_pkg::*;

    localparam int SW  = SAMPLE_WIDTH;
    localparam int EW  = SAMPLE_WIDTH + 1;
    localparam int CW  = (SW > REG_W) ? SW : REG_W;
    localparam int ECW = (EW > REG_W) ? EW : REG_W;
    localparam int KW  = (COUNTER_WIDTH > REG_W) ? COUNTER_WIDTH : REG_W;

    function automatic logic [SAMPLE_WIDTH-1:0] mag_s(input logic [SAMPLE_WIDTH-1:0] v);
        mag_s = v[SAMPLE_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    logic [SW-1:0]        pa, pb, pc, pab, peak;
    logic [CW-1:0]        peak_x;
    logic [SW-1:0]        cmd_abs, fdb_abs;
    logic signed [EW-1:0] diff;
    logic [EW-1:0]        err;
    logic [FLAGS_W-1:0]   fault;
    logic                 qualify;
    logic [COUNTER_WIDTH-1:0] cnt_inc;

    always_comb begin
        pa   = mag_s(i_phase_a_current);
        pb   = mag_s(i_phase_b_current);
        pc   = mag_s(i_phase_c_current);
        pab  = (pb > pa) ? pb : pa;
        peak = (pc > pab) ? pc : pab;
        peak_x = CW'(peak);

        cmd_abs = mag_s(i_speed_command);
        fdb_abs = mag_s(i_speed_feedback);
        diff    = EW'(i_speed_command) - EW'(i_speed_feedback);
        err     = diff[EW-1] ? (~diff + 1'b1) : diff;

        fault            = '0;
        fault[FLT_OC]    = peak_x > CW'(i_limits.oc_limit);
        fault[FLT_OV]    = i_bus_voltage > i_limits.ov_limit;
        fault[FLT_UV]    = i_bus_voltage < i_limits.uv_limit;

        qualify = i_motor_running
               && (CW'(cmd_abs) >= CW'(i_limits.stall_min_cmd))
               && (CW'(fdb_abs) <= CW'(i_limits.stall_max_fdb))
               && (ECW'(err) > ECW'(i_limits.stall_err_lim));

        cnt_inc = (i_stall_cnt != '1) ? i_stall_cnt + 1'b1 : i_stall_cnt;

        if (qualify) begin
            o_stall_cnt      = cnt_inc;
            fault[FLT_STALL] = KW'(cnt_inc) >= KW'(i_limits.stall_cnt_lim);
        end else begin
            o_stall_cnt = '0;
        end

        if (peak_x > CW'({PEAK_W{1'b1}})) begin
            o_peak = '1;
        end else begin
            o_peak = peak_x[PEAK_W-1:0];
        end
        o_latched = i_latched | fault;

        if (i_action == ACT_CLEAR) begin
            o_latched   = '0;
            o_stall_cnt = '0;
            o_peak      = '0;
        end
    end

endmodule

`default_nettype wire

>>> hdl/motor_fault_protection_monitor_unit.sv
// Top level of the motor fault protection monitor.
//
// Input channel (i_in_valid / o_in_stall) takes one item per cycle: a check
// sample (phase currents, bus voltage, speed command and feedback, running
// flag) or a clear item. Output channel (o_out_valid / i_out_stall) gives one
// result per item: sticky fault flags and the peak absolute phase current.
// An accepted item passes an input register, then the compare logic into the
// result register, which also holds the sticky flags and the stall counter.
// Throughput is one item per cycle while the receiver does not stall. When
// the receiver stalls, the result holds and the input register fills;
// o_in_stall rises only while both stages hold items. A clear item zeroes the
// flags and the stall counter and returns zero flags and zero peak.
// Synchronous reset empties both stages, clears flags and counter, and loads
// the limit registers with their reset values. The user must write limits
// through i_cfg_we / i_cfg_index / i_cfg_data only while the block is idle,
// not enforced by the block; indexes past the last register are ignored.
`default_nettype none

module motor_fault_protection_monitor_unit #(
    parameter int SAMPLE_WIDTH  = fmpm_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNTER_WIDTH = fmpm_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [fmpm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [fmpm_pkg::REG_W-1:0]     i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_action,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_phase_a_current,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_phase_b_current,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_phase_c_current,
    input  wire logic [fmpm_pkg::VBUS_W-1:0]    i_bus_voltage,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_speed_command,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_speed_feedback,
    input  wire logic                           i_motor_running,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [fmpm_pkg::FLAGS_W-1:0]        o_fault_flags,
    output logic [fmpm_pkg::PEAK_W-1:0]         o_peak_current
);
    import fmpm_pkg::*;

    t_limits limits;

    logic                           r_s1_valid;
    logic                           r_s1_action;
    logic signed [SAMPLE_WIDTH-1:0] r_s1_pa, r_s1_pb, r_s1_pc;
    logic [VBUS_W-1:0]              r_s1_vbus;
    logic signed [SAMPLE_WIDTH-1:0] r_s1_cmd, r_s1_fdb;
    logic                           r_s1_running;

    logic                     r_out_valid;
    logic [FLAGS_W-1:0]       r_latched;
    logic [COUNTER_WIDTH-1:0] r_stall_cnt;
    logic [PEAK_W-1:0]        r_peak;

    logic [FLAGS_W-1:0]       n_latched;
    logic [COUNTER_WIDTH-1:0] n_stall_cnt;
    logic [PEAK_W-1:0]        n_peak;

    logic adv;
    logic load;
    logic step;

    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !adv;
    assign load       = !o_in_stall;
    assign step       = adv && r_s1_valid;

    fmpm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_limits    (limits)
    );

    fmpm_eval #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_eval (
        .i_action          (r_s1_action),
        .i_phase_a_current (r_s1_pa),
        .i_phase_b_current (r_s1_pb),
        .i_phase_c_current (r_s1_pc),
        .i_bus_voltage     (r_s1_vbus),
        .i_speed_command   (r_s1_cmd),
        .i_speed_feedback  (r_s1_fdb),
        .i_motor_running   (r_s1_running),
        .i_limits          (limits),
        .i_latched         (r_latched),
        .i_stall_cnt       (r_stall_cnt),
        .o_latched         (n_latched),
        .o_stall_cnt       (n_stall_cnt),
        .o_peak            (n_peak)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_latched   <= '0;
            r_stall_cnt <= '0;
        end else begin
            if (load) begin
                r_s1_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= r_s1_valid;
            end
            if (step) begin
                r_latched   <= n_latched;
                r_stall_cnt <= n_stall_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_in_valid) begin
            r_s1_action  <= i_action;
            r_s1_pa      <= i_phase_a_current;
            r_s1_pb      <= i_phase_b_current;
            r_s1_pc      <= i_phase_c_current;
            r_s1_vbus    <= i_bus_voltage;
            r_s1_cmd     <= i_speed_command;
            r_s1_fdb     <= i_speed_feedback;
            r_s1_running <= i_motor_running;
        end
        if (step) begin
            r_peak <= n_peak;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_fault_flags  = r_latched;
    assign o_peak_current = r_peak;

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_s1_action == ACT_CLEAR) |=>
        (o_fault_flags == '0 && o_peak_current == '0 && r_stall_cnt == '0))
        else $error("clear item did not zero flags, peak and stall counter");

    a_flags_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_s1_action == ACT_CHECK) |=>
        ((o_fault_flags & $past(o_fault_flags)) == $past(o_fault_flags)))
        else $error("fault flag dropped without a clear item");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !step |=> ($stable(r_stall_cnt) && $stable(o_fault_flags)))
        else $error("monitor state changed without an item");

    a_stall_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_peak_current)))
        else $error("stalled result lost or changed");

endmodule

`default_nettype wire

>>> test/motor_fault_protection_monitor_unit_tb.sv
// Self-checking testbench for the motor fault protection monitor top level.
`default_nettype none

module motor_fault_protection_monitor_unit_tb;
    import fmpm_pkg::*;

    localparam int SW            = SAMPLE_WIDTH_DEF;
    localparam int CW            = COUNTER_WIDTH_DEF;
    localparam int PHASE_ITEMS   = 56;
    localparam int RUN_ITEMS     = 40;
    localparam int TIMEOUT_UNITS = 3_000_000;

    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED = 3'd7;

    localparam logic [FLAGS_W-1:0] F_NONE  = '0;
    localparam logic [FLAGS_W-1:0] F_OC    = FLAGS_W'(1 << FLT_OC);
    localparam logic [FLAGS_W-1:0] F_OV    = FLAGS_W'(1 << FLT_OV);
    localparam logic [FLAGS_W-1:0] F_UV    = FLAGS_W'(1 << FLT_UV);
    localparam logic [FLAGS_W-1:0] F_STALL = FLAGS_W'(1 << FLT_STALL);

    typedef struct packed {
        logic              action;
        logic [SW-1:0]     pa;
        logic [SW-1:0]     pb;
        logic [SW-1:0]     pc;
        logic [VBUS_W-1:0] vbus;
        logic [SW-1:0]     cmd;
        logic [SW-1:0]     fdb;
        logic              running;
    } t_item;

    typedef struct packed {
        logic [FLAGS_W-1:0] flags;
        logic [PEAK_W-1:0]  peak;
    } t_report;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [REG_W-1:0]   data;
        t_item              item;
        logic               typed;
        logic [FLAGS_W-1:0] flags;
        logic [PEAK_W-1:0]  peak;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [REG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_action;
    logic [SW-1:0]        i_phase_a_current;
    logic [SW-1:0]        i_phase_b_current;
    logic [SW-1:0]        i_phase_c_current;
    logic [VBUS_W-1:0]    i_bus_voltage;
    logic [SW-1:0]        i_speed_command;
    logic [SW-1:0]        i_speed_feedback;
    logic                 i_motor_running;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [FLAGS_W-1:0]   o_fault_flags;
    logic [PEAK_W-1:0]    o_peak_current;

    // predictor state
    t_limits            lim_mirror;
    logic [FLAGS_W-1:0] sticky_mirror;
    logic [CW-1:0]      stall_cnt_mirror;

    t_report awaited_reports[$];
    t_row    dir_rows[$];
    t_report got_report;

    int errors         = 0;
    int n_items        = 0;
    int n_clears       = 0;
    int n_results      = 0;
    int n_stall_flags  = 0;
    int n_backpressure = 0;
    int send_gap_pct   = 0;
    int recv_hold_pct  = 0;
    int recv_hold_left = 0;

    motor_fault_protection_monitor_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_action          (i_action),
        .i_phase_a_current (i_phase_a_current),
        .i_phase_b_current (i_phase_b_current),
        .i_phase_c_current (i_phase_c_current),
        .i_bus_voltage     (i_bus_voltage),
        .i_speed_command   (i_speed_command),
        .i_speed_feedback  (i_speed_feedback),
        .i_motor_running   (i_motor_running),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_fault_flags     (o_fault_flags),
        .o_peak_current    (o_peak_current)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int mag16(logic [SW-1:0] v);
        int s;
        s = int'($signed(v));
        return (s < 0) ? -s : s;
    endfunction

    function automatic logic [SW-1:0] smp(int m, bit neg);
        logic [SW-1:0] v;
        v = SW'(m);
        if (neg) v = -v;
        return v;
    endfunction

    function automatic logic [15:0] near16(int centre, int spread);
        int v;
        v = centre + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return 16'(v);
    endfunction

    function automatic t_item mk_item(logic act, logic [SW-1:0] pa, logic [SW-1:0] pb,
                                      logic [SW-1:0] pc, logic [VBUS_W-1:0] vbus,
                                      logic [SW-1:0] cmd, logic [SW-1:0] fdb, logic run);
        t_item it;
        it.action  = act;
        it.pa      = pa;
        it.pb      = pb;
        it.pc      = pc;
        it.vbus    = vbus;
        it.cmd     = cmd;
        it.fdb     = fdb;
        it.running = run;
        return it;
    endfunction

    function automatic t_row item_row(t_item it, logic typed, logic [FLAGS_W-1:0] flags,
                                      logic [PEAK_W-1:0] peak);
        t_row r;
        r.kind  = ROW_ITEM;
        r.idx   = '0;
        r.data  = '0;
        r.item  = it;
        r.typed = typed;
        r.flags = flags;
        r.peak  = peak;
        return r;
    endfunction

    function automatic t_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
        t_row r;
        r       = item_row('0, 1'b0, '0, '0);
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.data  = data;
        return r;
    endfunction

    // one protection step on the mirrored state
    task automatic protect_step(input t_item it, output t_report r);
        int peak;
        int err_m;
        logic [FLAGS_W-1:0] hit;
        hit = '0;
        if (it.action == ACT_CLEAR) begin
            sticky_mirror    = '0;
            stall_cnt_mirror = '0;
            r.flags          = '0;
            r.peak           = '0;
        end else begin
            peak = mag16(it.pa);
            if (mag16(it.pb) > peak) peak = mag16(it.pb);
            if (mag16(it.pc) > peak) peak = mag16(it.pc);
            if (peak > int'(lim_mirror.oc_limit)) hit[FLT_OC] = 1'b1;
            if (it.vbus > lim_mirror.ov_limit) hit[FLT_OV] = 1'b1;
            if (it.vbus < lim_mirror.uv_limit) hit[FLT_UV] = 1'b1;
            err_m = int'($signed(it.cmd)) - int'($signed(it.fdb));
            if (err_m < 0) err_m = -err_m;
            if (it.running && mag16(it.cmd) >= int'(lim_mirror.stall_min_cmd)
                    && mag16(it.fdb) <= int'(lim_mirror.stall_max_fdb)
                    && err_m > int'(lim_mirror.stall_err_lim)) begin
                if (stall_cnt_mirror != '1) stall_cnt_mirror = stall_cnt_mirror + 1'b1;
                if (stall_cnt_mirror >= CW'(lim_mirror.stall_cnt_lim)) hit[FLT_STALL] = 1'b1;
            end else begin
                stall_cnt_mirror = '0;
            end
            sticky_mirror = sticky_mirror | hit;
            r.flags = sticky_mirror;
            r.peak  = (peak > 65535) ? '1 : PEAK_W'(peak);
        end
    endtask

    // mostly stall-prone and near-threshold samples, some noise and clears
    function automatic t_item gen_item();
        t_item it;
        int pick;
        int m;
        pick       = $urandom_range(0, 99);
        it.action  = ACT_CHECK;
        it.pa      = SW'($urandom);
        it.pb      = SW'($urandom);
        it.pc      = SW'($urandom);
        it.vbus    = VBUS_W'($urandom);
        it.cmd     = SW'($urandom);
        it.fdb     = SW'($urandom);
        it.running = ($urandom_range(0, 1) == 1);
        if (pick < 6) begin
            it.action = ACT_CLEAR;
        end else if (pick < 28) begin
            // fully random sample
        end else if (pick < 50) begin
            m     = int'(near16(int'(lim_mirror.oc_limit), 3));
            it.pa = smp(m, $urandom_range(0, 1) == 1);
            it.pb = smp(int'($urandom_range(0, lim_mirror.oc_limit)), $urandom_range(0, 1) == 1);
            it.pc = smp(int'($urandom_range(0, lim_mirror.oc_limit)), $urandom_range(0, 1) == 1);
            if ($urandom_range(0, 1) == 1) it.vbus = near16(int'(lim_mirror.ov_limit), 2);
            else it.vbus = near16(int'(lim_mirror.uv_limit), 2);
        end else begin
            m      = int'($urandom_range(lim_mirror.stall_min_cmd, 32768));
            it.cmd = smp(m, $urandom_range(0, 1) == 1);
            m      = int'($urandom_range(0, lim_mirror.stall_max_fdb));
            it.fdb = smp(m, $urandom_range(0, 1) == 1);
            it.running = ($urandom_range(0, 9) != 0);
            it.pa   = smp(int'($urandom_range(0, 32768)), $urandom_range(0, 1) == 1);
        end
        return it;
    endfunction

    task automatic send_item(input t_item it, input logic typed,
                             input logic [FLAGS_W-1:0] ef, input logic [PEAK_W-1:0] ep);
        t_report r;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid        <= 1'b1;
        i_action          <= it.action;
        i_phase_a_current <= it.pa;
        i_phase_b_current <= it.pb;
        i_phase_c_current <= it.pc;
        i_bus_voltage     <= it.vbus;
        i_speed_command   <= it.cmd;
        i_speed_feedback  <= it.fdb;
        i_motor_running   <= it.running;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        protect_step(it, r);
        if (typed) begin
            r.flags = ef;
            r.peak  = ep;
        end
        awaited_reports.push_back(r);
        n_items++;
        if (it.action == ACT_CLEAR) n_clears++;
    endtask

    // sender holds off until every awaited result is back
    task automatic drain_reports();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (awaited_reports.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] d);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (t_reg_idx'(idx))
            REG_OC_LIMIT:      lim_mirror.oc_limit      = d;
            REG_OV_LIMIT:      lim_mirror.ov_limit      = d;
            REG_UV_LIMIT:      lim_mirror.uv_limit      = d;
            REG_STALL_ERR_LIM: lim_mirror.stall_err_lim = d;
            REG_STALL_CNT_LIM: lim_mirror.stall_cnt_lim = d;
            REG_STALL_MIN_CMD: lim_mirror.stall_min_cmd = d;
            REG_STALL_MAX_FDB: lim_mirror.stall_max_fdb = d;
            default: ;
        endcase
    endtask

    task automatic apply_limits(input t_limits l);
        drain_reports();
        write_reg(REG_OC_LIMIT, l.oc_limit);
        write_reg(REG_OV_LIMIT, l.ov_limit);
        write_reg(REG_UV_LIMIT, l.uv_limit);
        write_reg(REG_STALL_ERR_LIM, l.stall_err_lim);
        write_reg(REG_STALL_CNT_LIM, l.stall_cnt_lim);
        write_reg(REG_STALL_MIN_CMD, l.stall_min_cmd);
        write_reg(REG_STALL_MAX_FDB, l.stall_max_fdb);
        write_reg(IDX_UNUSED, REG_W'($urandom));
    endtask

    // receiver: random stalls plus an occasional long hold-off
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (recv_hold_left > 0) begin
                recv_hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_hold_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_stall) n_backpressure++;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (o_fault_flags[FLT_STALL]) n_stall_flags++;
            if (awaited_reports.size() == 0) begin
                $display("%0t: result with none awaited: flags=%h peak=%0d",
                         $time, o_fault_flags, o_peak_current);
                errors++;
            end else begin
                got_report = awaited_reports.pop_front();
                if (o_fault_flags !== got_report.flags) begin
                    $display("%0t: fault_flags expected %h actual %h",
                             $time, got_report.flags, o_fault_flags);
                    errors++;
                end
                if (o_peak_current !== got_report.peak) begin
                    $display("%0t: peak_current expected %0d actual %0d",
                             $time, got_report.peak, o_peak_current);
                    errors++;
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_UNITS);
        $display("%0t: timeout", $time);
        $display("FAIL motor_fault_protection_monitor_unit");
        $finish;
    end

    initial begin
        t_limits lim;
        t_item   it;
        int      waited;

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = '0;
        i_cfg_data        = '0;
        i_in_valid        = 1'b0;
        i_action          = ACT_CHECK;
        i_phase_a_current = '0;
        i_phase_b_current = '0;
        i_phase_c_current = '0;
        i_bus_voltage     = '0;
        i_speed_command   = '0;
        i_speed_feedback  = '0;
        i_motor_running   = 1'b0;

        lim_mirror.oc_limit      = RST_OC_LIMIT;
        lim_mirror.ov_limit      = RST_OV_LIMIT;
        lim_mirror.uv_limit      = RST_UV_LIMIT;
        lim_mirror.stall_err_lim = RST_STALL_ERR_LIM;
        lim_mirror.stall_cnt_lim = RST_STALL_CNT_LIM;
        lim_mirror.stall_min_cmd = RST_STALL_MIN_CMD;
        lim_mirror.stall_max_fdb = RST_STALL_MAX_FDB;
        sticky_mirror    = '0;
        stall_cnt_mirror = '0;

        // reset limits: current extremes, most negative current, bus extremes
        dir_rows.push_back(item_row(mk_item(ACT_CHECK, 0, 0, 0, 0, 0, 0, 0), 1, F_NONE, 0));
        dir_rows.push_back(item_row(mk_item(ACT_CHECK, 16'h8000, 0, 0, 0, 0, 0, 0),
                                    1, F_NONE, 16'd32768));
        dir_rows.push_back(item_row(mk_item(ACT_CHECK, 16'h7FFF, 16'h8001, 16'h8000,
                                            16'd1000, 0, 0, 1), 1, F_NONE, 16'd32768));
        dir_rows.push_back(item_row(mk_item(ACT_CHECK, 16'hFFFF, 16'h7FFF, 16'h0001,
                                            16'hFFFF, 0, 0, 0), 1, F_NONE, 16'd32767));
        dir_rows.push_back(item_row(mk_item(ACT_CHECK, 0, 0, 0, 0, 16'h7FFF, 16'h8000, 1),
                                    1, F_NONE, 0));
        dir_rows.push_back(item_row(mk_item(ACT_CHECK, 0, 0, 0, 16'h8000, 16'h8000, 0, 1),
                                    1, F_NONE, 0));
        // overcurrent boundary, sticky bit, clear
        dir_rows.push_back(cfg_row(REG_OC_LIMIT, 16'd100));
        dir_rows.push_back(item_row(mk_item(ACT_CHECK, 16'd100, 16'hFF9C, 0, 16'd10, 0, 0, 0),
                                    1, F_NONE, 16'd100));
        dir_rows.push_back(item_row(mk_item(ACT_CHECK, 0, 0, 16'hFF9B, 16'd10, 0, 0, 0),
                                    1, F_OC, 16'd101));
        dir_rows.push_back(item_row(mk_item(ACT_CHECK, 0, 0, 0, 0, 0, 0, 0), 1, F_OC, 0));
        dir_rows.push_back(item_row(mk_item(ACT_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                            16'hFFFF, 16'hFFFF, 1), 1, F_NONE, 0));
        // bus voltage window
        dir_rows.push_back(cfg_row(REG_OV_LIMIT, 16'd1000));
        dir_rows.push_back(cfg_row(REG_UV_LIMIT, 16'd500));
        dir_rows.push_back(item_row(mk_item(ACT_CHECK, 0, 0, 0, 16'd1000, 0, 0, 0),
                                    1, F_NONE, 0));
        dir_rows.push_back(item_row(mk_item(ACT_CHECK, 0, 0, 0, 16'd1001, 0, 0, 0),
                                    1, F_OV, 0));
        dir_rows.push_back(item_row(mk_item(ACT_CHECK, 0, 0, 0, 16'd499, 0, 0, 0),
                                    1, F_OV | F_UV, 0));
        dir_rows.push_back(item_row(mk_item(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, F_NONE, 0));
        // write to a missing register changes nothing
        dir_rows.push_back(cfg_row(IDX_UNUSED, 16'd0));
        dir_rows.push_back(item_row(mk_item(ACT_CHECK, 16'd50, 0, 0, 16'd500, 0, 0, 0),
                                    1, F_NONE, 16'd50));
        // zero stall count limit trips on the first qualifying sample
        dir_rows.push_back(cfg_row(REG_STALL_ERR_LIM, 16'd10));
        dir_rows.push_back(cfg_row(REG_STALL_CNT_LIM, 16'd0));
        dir_rows.push_back(cfg_row(REG_STALL_MIN_CMD, 16'd32768));
        dir_rows.push_back(cfg_row(REG_STALL_MAX_FDB, 16'd32768));
        dir_rows.push_back(item_row(mk_item(ACT_CHECK, 0, 0, 0, 16'd700, 16'h8000, 0, 1),
                                    1, F_STALL, 0));
        dir_rows.push_back(item_row(mk_item(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, F_NONE, 0));
        // stall counting with breaks and qualification boundaries
        dir_rows.push_back(cfg_row(REG_STALL_CNT_LIM, 16'd3));
        dir_rows.push_back(cfg_row(REG_STALL_MIN_CMD, 16'd1000));
        dir_rows.push_back(cfg_row(REG_STALL_MAX_FDB, 16'd50));
        dir_rows.push_back(item_row(mk_item(ACT_CHECK, 0, 0, 0, 16'd700, 16'd2000, 16'd50, 1),
                                    0, '0, '0));
        dir_rows.push_back(item_row(mk_item(ACT_CHECK, 0, 0, 0, 16'd700, 16'hFC18, 16'hFFCE, 1),
                                    0, '0, '0));
        dir_rows.push_back(item_row(mk_item(ACT_CHECK, 0, 0, 0, 16'd700, 16'hFC18, 16'hFFCE, 0),
                                    0, '0, '0));
        dir_rows.push_back(item_row(mk_item(ACT_CHECK, 0, 0, 0, 16'd700, 16'd999, 0, 1),
                                    0, '0, '0));
        dir_rows.push_back(item_row(mk_item(ACT_CHECK, 0, 0, 0, 16'd700, 16'd1000, 16'd51, 1),
                                    0, '0, '0));
        dir_rows.push_back(item_row(mk_item(ACT_CHECK, 0, 0, 0, 16'd700, 16'd1000, 0, 1),
                                    0, '0, '0));
        dir_rows.push_back(item_row(mk_item(ACT_CHECK, 0, 0, 0, 16'd700, 16'h8000, 16'hFFCE, 1),
                                    0, '0, '0));
        dir_rows.push_back(item_row(mk_item(ACT_CHECK, 0, 0, 0, 16'd700, 16'h7FFF, 16'd50, 1),
                                    0, '0, '0));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                drain_reports();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].flags,
                          dir_rows[i].peak);
            end
        end

        // long unbroken run of qualifying samples past the stall count limit
        lim.oc_limit      = RST_OC_LIMIT;
        lim.ov_limit      = RST_OV_LIMIT;
        lim.uv_limit      = RST_UV_LIMIT;
        lim.stall_err_lim = '0;
        lim.stall_cnt_lim = 16'd30;
        lim.stall_min_cmd = '0;
        lim.stall_max_fdb = 16'd32768;
        apply_limits(lim);
        send_item(mk_item(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0), 0, '0, '0);
        for (int k = 0; k < RUN_ITEMS; k++) begin
            it = gen_item();
            it.action  = ACT_CHECK;
            it.running = 1'b1;
            if (it.cmd == it.fdb) it.cmd[0] = ~it.cmd[0];
            send_item(it, 0, '0, '0);
        end

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: lim = '0;
                1: begin
                    lim.oc_limit      = 16'd32768;
                    lim.ov_limit      = 16'hFFFF;
                    lim.uv_limit      = 16'hFFFF;
                    lim.stall_err_lim = 16'hFFFF;
                    lim.stall_cnt_lim = 16'hFFFF;
                    lim.stall_min_cmd = 16'd32768;
                    lim.stall_max_fdb = 16'd32768;
                end
                default: begin
                    lim.oc_limit      = 16'($urandom_range(0, 32768));
                    lim.ov_limit      = 16'($urandom_range(30000, 65535));
                    lim.uv_limit      = 16'($urandom_range(0, 30000));
                    lim.stall_err_lim = 16'($urandom_range(0, 3000));
                    lim.stall_cnt_lim = 16'($urandom_range(0, 5));
                    lim.stall_min_cmd = 16'($urandom_range(0, 20000));
                    lim.stall_max_fdb = 16'($urandom_range(0, 20000));
                end
            endcase
            apply_limits(lim);
            case (ph)
                1:       begin send_gap_pct = 51; recv_hold_pct = 0;  end
                2:       begin send_gap_pct = 0;  recv_hold_pct = 51; end
                3, 4:    begin send_gap_pct = 20; recv_hold_pct = 20; end
                default: begin send_gap_pct = 0;  recv_hold_pct = 0;  end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 0 && k == 20) recv_hold_left = 40;
                if (ph == 2 && k == 35) drain_reports();
                send_item(gen_item(), 0, '0, '0);
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        waited = 0;
        while (awaited_reports.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        if (awaited_reports.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, awaited_reports.size());
            errors += awaited_reports.size();
        end
        repeat (8) @(posedge i_clk);

        $display("Run: %0d items (%0d clears), %0d results checked, %0d with stall flag set",
                 n_items, n_clears, n_results, n_stall_flags);
        $display("Directed table, long stall run, 6 limit settings; %0d stalled input cycles",
                 n_backpressure);
        if (errors == 0) begin
            $display("PASS motor_fault_protection_monitor_unit");
        end else begin
            $display("FAIL motor_fault_protection_monitor_unit");
        end
        $finish;
    end

endmodule

`default_nettype wire
